[hw/rtl/pqmx_pkg.sv]
package pqmx_pkg;

    // Queue geometry
    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Entry fields, stored as {value, priority}
    localparam int VAL_W = 32;
    localparam int PRI_W = 16;
    localparam int ENT_W = VAL_W + PRI_W;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    localparam int ST_W = 2;
    typedef logic [ST_W-1:0] t_status;
    localparam t_status ST_INSERTED  = 2'd0;
    localparam t_status ST_REMOVED   = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_UNDERFLOW = 2'd3;

    // Control from the sequencer to the compare unit
    typedef struct packed {
        logic en;     // a live slot is on the read data this cycle
        logic first;  // it is slot 0, take it unconditionally
    } t_cmp_ctl;

endpackage

[hw/rtl/pqmx_ram.sv]
module pqmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pqmx_cmp.sv]
module pqmx_cmp (
    input  logic                                i_clk,
    input  pqmx_pkg::t_cmp_ctl                  i_ctl,
    input  logic [pqmx_pkg::IDX_W-1:0]          i_idx,
    input  logic signed [pqmx_pkg::VAL_W-1:0]   i_value,
    input  logic signed [pqmx_pkg::PRI_W-1:0]   i_prio,
    output logic [pqmx_pkg::IDX_W-1:0]          o_best_idx,
    output logic signed [pqmx_pkg::VAL_W-1:0]   o_best_value,
    output logic signed [pqmx_pkg::PRI_W-1:0]   o_best_prio
);
    import pqmx_pkg::*;

    logic [IDX_W-1:0]        r_best_idx;
    logic signed [VAL_W-1:0] r_best_value;
    logic signed [PRI_W-1:0] r_best_prio;
    logic                    take;

    // Strictly greater replaces, so the oldest entry wins a tie
    assign take = i_ctl.first || (i_prio > r_best_prio);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && take) begin
            r_best_idx   <= i_idx;
            r_best_value <= i_value;
            r_best_prio  <= i_prio;
        end
    end

    assign o_best_idx   = r_best_idx;
    assign o_best_value = r_best_value;
    assign o_best_prio  = r_best_prio;

endmodule

[hw/rtl/priority_queue_max_extract.sv]
// Channel   Handshake            Ports
// --------  -------------------  ---------------------------------------------------
// request   start & !busy        i_cmd, i_item_value, i_item_priority
// result    o_strobe (1 cycle)   o_status, o_out_value, o_out_priority, o_fill_count
//
// Insert, overflow and underflow strobe their result in the cycle after the request,
// and busy stays low. A remove of N live entries scans them through one compare unit
// at one slot a cycle off the registered RAM read, then compacts younger entries one
// slot a cycle; busy stays high through the scan and the compaction.
// Reset (i_rst_n, synchronous, active low) empties the queue; slot contents need none.
// The receiver cannot stall: o_strobe marks each result for exactly one cycle.
module priority_queue_max_extract (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic signed [pqmx_pkg::VAL_W-1:0]   i_item_value,
    input  logic signed [pqmx_pkg::PRI_W-1:0]   i_item_priority,
    output logic                                o_strobe,
    output pqmx_pkg::t_status                   o_status,
    output logic signed [pqmx_pkg::VAL_W-1:0]   o_out_value,
    output logic signed [pqmx_pkg::PRI_W-1:0]   o_out_priority,
    output logic [pqmx_pkg::CNT_W-1:0]          o_fill_count
);
    import pqmx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_PREP  = 4'b0100,
        S_SHIFT = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_strobe, n_strobe;
    t_status                 r_status, n_status;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic signed [PRI_W-1:0] r_prio, n_prio;
    logic [CNT_W-1:0]        r_fill, n_fill;

    logic                    accept;
    logic                    full;
    logic                    last_scan;
    logic                    more_shift;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENT_W-1:0]        ram_rdata;
    t_cmp_ctl                cmp_ctl;
    logic [IDX_W-1:0]        best_idx;
    logic signed [VAL_W-1:0] best_value;
    logic signed [PRI_W-1:0] best_prio;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full   = (r_count >= CNT_W'(DEPTH));

    // Slot r_idx is on the read data during the scan
    assign last_scan  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    // Slot r_idx+1 is on the read data during compaction
    assign more_shift = (CNT_W'(r_idx) + CNT_W'(2)) <= r_count;

    // Slot storage
    assign ram_we    = (accept && (i_cmd == CMD_INSERT) && !full)
                     || ((r_state == S_SHIFT) && more_shift);
    assign ram_waddr = (r_state == S_IDLE) ? r_count[IDX_W-1:0] : r_idx;
    assign ram_wdata = (r_state == S_IDLE) ? {i_item_value, i_item_priority} : ram_rdata;

    always_comb begin
        unique case (r_state)
            S_IDLE:  ram_raddr = '0;
            S_SCAN:  ram_raddr = r_idx + IDX_W'(1);
            S_PREP:  ram_raddr = best_idx + IDX_W'(1);
            S_SHIFT: ram_raddr = r_idx + IDX_W'(2);
            default: ram_raddr = '0;
        endcase
    end

    pqmx_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Running maximum over the scanned slots
    assign cmp_ctl.en    = (r_state == S_SCAN);
    assign cmp_ctl.first = (r_idx == '0);

    pqmx_cmp u_cmp (
        .i_clk        (i_clk),
        .i_ctl        (cmp_ctl),
        .i_idx        (r_idx),
        .i_value      (ram_rdata[ENT_W-1:PRI_W]),
        .i_prio       (ram_rdata[PRI_W-1:0]),
        .o_best_idx   (best_idx),
        .o_best_value (best_value),
        .o_best_prio  (best_prio)
    );

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_strobe = 1'b0;
        n_status = r_status;
        n_value  = r_value;
        n_prio   = r_prio;
        n_fill   = r_fill;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value = '0;
                    n_prio  = '0;
                    if (i_cmd == CMD_INSERT) begin
                        n_strobe = 1'b1;
                        if (full) begin
                            n_status = ST_OVERFLOW;
                            n_fill   = r_count;
                        end else begin
                            n_status = ST_INSERTED;
                            n_count  = r_count + CNT_W'(1);
                            n_fill   = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_strobe = 1'b1;
                        n_status = ST_UNDERFLOW;
                        n_fill   = r_count;
                    end else begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                    end
                end
            end
            S_SCAN: begin
                if (last_scan) begin
                    n_state = S_PREP;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_PREP: begin
                n_state = S_SHIFT;
                n_idx   = best_idx;
            end
            S_SHIFT: begin
                if (more_shift) begin
                    n_idx = r_idx + IDX_W'(1);
                end else begin
                    n_state  = S_IDLE;
                    n_count  = r_count - CNT_W'(1);
                    n_strobe = 1'b1;
                    n_status = ST_REMOVED;
                    n_value  = best_value;
                    n_prio   = best_prio;
                    n_fill   = r_count - CNT_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Index and result payload
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        r_value  <= n_value;
        r_prio   <= n_prio;
        r_fill   <= n_fill;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_prio;
    assign o_fill_count   = r_fill;

endmodule
